// ===== rtl/core/wbc_pkg.sv =====
`timescale 1ns / 1ps

package wbc_pkg;

  localparam int unsigned TREE_NODES = 4096;
  localparam int unsigned SLOT_COUNT = 7;
  localparam int unsigned LEAF_LIMIT = 3;

  localparam int unsigned NODE_W  = $clog2(TREE_NODES);
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned PRIM_W  = 8;
  localparam int unsigned COST_AW = $clog2(TREE_NODES * SLOT_COUNT);

  localparam logic [COST_W-1:0] COST_INF  = '1;
  localparam logic [SLOT_W-1:0] NO_SLOT   = 3'd7;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [COST_AW-1:0] cost_addr_t;

  typedef enum logic [1:0] {
    KIND_LEAF       = 2'd0,
    KIND_INTERNAL   = 2'd1,
    KIND_DISTRIBUTE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAF,
    ST_PAIR,
    ST_GAP,
    ST_FIN0,
    ST_DRAIN,
    ST_WB
  } state_e;

  // one child slot pair in flight, aligned with the memory read data
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] k;
    logic [SLOT_W-1:0] j;
  } pair_t;

  typedef struct packed {
    logic              init;
    logic              leaf;
    logic              prim_valid;
    logic              fin0;
    logic              emit_leaf;
    logic [SLOT_W-1:0] idx;
    logic              rc_oob;
    logic [COST_W-1:0] area;
    pair_t             cmp;
  } ctl_t;

  typedef struct packed {
    cost_addr_t rd_a;
    cost_addr_t rd_b;
    cost_addr_t wr;
    logic       cost_we;
    node_t      prim_rd_a;
    node_t      prim_rd_b;
    node_t      prim_wr;
    logic       prim_we;
  } mem_req_t;

endpackage

// ===== rtl/core/wide_bvh_collapse_cost_dp_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// node      in         start high, busy low         node_id, is_leaf, left_child,
//                                                   box_area
// result    out        result_valid_o, one cycle    slot, slot_cost, decision_kind,
//                                                   split_left, split_right,
//                                                   primitive_total, last_slot
//
// one node transaction at a time; busy stays high until its write-back is done
// inner node: the 28 child slot pairs are read one pair a cycle from the dual-read
// cost memory, with a gap and a slot-0 close after the slot-0 pairs, then a drain
// and a write-back of each slot
// leaf node: 7 results, then a write-back of each slot
// reset clears the sequencer and the result valid flag only; memory contents stay undefined until written
// results cannot be stalled and appear one cycle each, slot 0 first

module wide_bvh_collapse_cost_dp_unit import wbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [NODE_W-1:0] node_id_i,
  input  logic              is_leaf_i,
  input  logic [NODE_W-1:0] left_child_i,
  input  logic [COST_W-1:0] box_area_i,
  output logic              result_valid_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [COST_W-1:0] slot_cost_o,
  output logic [1:0]        decision_kind_o,
  output logic [SLOT_W-1:0] split_left_o,
  output logic [SLOT_W-1:0] split_right_o,
  output logic [PRIM_W-1:0] primitive_total_o,
  output logic              last_slot_o
);

  ctl_t              ctl;
  mem_req_t          mem;
  logic [COST_W-1:0] lcost, rcost, wb_cost;
  logic [PRIM_W-1:0] lprim, rprim, wb_prim;

  wbc_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .node_id_i      (node_id_i),
    .is_leaf_i      (is_leaf_i),
    .left_child_i   (left_child_i),
    .box_area_i     (box_area_i),
    .ctl_o          (ctl),
    .mem_o          (mem)
  );

  wbc_ram #(
    .WIDTH (COST_W),
    .DEPTH (TREE_NODES * SLOT_COUNT)
  ) u_cost_ram (
    .clk_i     (clk_i),
    .we_i      (mem.cost_we),
    .waddr_i   (mem.wr),
    .wdata_i   (wb_cost),
    .raddr_a_i (mem.rd_a),
    .rdata_a_o (lcost),
    .raddr_b_i (mem.rd_b),
    .rdata_b_o (rcost)
  );

  wbc_ram #(
    .WIDTH (PRIM_W),
    .DEPTH (TREE_NODES)
  ) u_prim_ram (
    .clk_i     (clk_i),
    .we_i      (mem.prim_we),
    .waddr_i   (mem.prim_wr),
    .wdata_i   (wb_prim),
    .raddr_a_i (mem.prim_rd_a),
    .rdata_a_o (lprim),
    .raddr_b_i (mem.prim_rd_b),
    .rdata_b_o (rprim)
  );

  wbc_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .lcost_i     (lcost),
    .rcost_i     (rcost),
    .lprim_i     (lprim),
    .rprim_i     (rprim),
    .wb_cost_o   (wb_cost),
    .wb_prim_o   (wb_prim),
    .res_valid_o (result_valid_o),
    .res_slot_o  (slot_o),
    .res_cost_o  (slot_cost_o),
    .res_kind_o  (decision_kind_o),
    .res_left_o  (split_left_o),
    .res_right_o (split_right_o),
    .res_prims_o (primitive_total_o),
    .res_last_o  (last_slot_o)
  );

endmodule

// ===== rtl/core/wbc_ram.sv =====
`timescale 1ns / 1ps

module wbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/core/wbc_seq.sv =====
`timescale 1ns / 1ps

module wbc_seq import wbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [NODE_W-1:0]   node_id_i,
  input  logic                is_leaf_i,
  input  logic [NODE_W-1:0]   left_child_i,
  input  logic [COST_W-1:0]   box_area_i,
  output ctl_t                ctl_o,
  output mem_req_t            mem_o
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic              first_q, first_d;
  pair_t             cmp_q, cmp_d;
  cost_addr_t        lc_base_q, rc_base_q, ni_base_q;
  node_t             ni_q;
  logic [COST_W-1:0] area_q;
  logic              rc_oob_q;

  logic [NODE_W:0]   rc_full;
  logic              rc_oob;
  logic              accept;
  logic [SLOT_W-1:0] j;
  logic              pair_last;

  function automatic cost_addr_t node_base(node_t n);
    return cost_addr_t'(n) * cost_addr_t'(SLOT_COUNT);
  endfunction

  assign rc_full = {1'b0, left_child_i} + (NODE_W + 1)'(1);
  assign rc_oob  = rc_full >= (NODE_W + 1)'(TREE_NODES);
  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = state_q != ST_IDLE;

  assign j = (slot_q == '0) ? (LAST_SLOT - k_q) : (slot_q - SLOT_W'(1) - k_q);
  assign pair_last = (slot_q == '0) ? (k_q == LAST_SLOT) : (k_q == slot_q - SLOT_W'(1));

  always_comb begin
    state_d           = state_q;
    slot_d            = slot_q;
    k_d               = k_q;
    first_d           = 1'b0;
    cmp_d             = '0;
    ctl_o.init        = 1'b0;
    ctl_o.leaf        = is_leaf_i;
    ctl_o.prim_valid  = first_q;
    ctl_o.fin0        = 1'b0;
    ctl_o.emit_leaf   = 1'b0;
    ctl_o.idx         = slot_q;
    ctl_o.rc_oob      = rc_oob_q;
    ctl_o.area        = area_q;
    ctl_o.cmp         = cmp_q;
    mem_o.rd_a        = lc_base_q + cost_addr_t'(k_q);
    mem_o.rd_b        = rc_base_q + cost_addr_t'(j);
    mem_o.wr          = ni_base_q + cost_addr_t'(slot_q);
    mem_o.cost_we     = 1'b0;
    mem_o.prim_rd_a   = left_child_i;
    mem_o.prim_rd_b   = rc_full[NODE_W-1:0];
    mem_o.prim_wr     = ni_q;
    mem_o.prim_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctl_o.init = 1'b1;
          slot_d     = '0;
          k_d        = '0;
          first_d    = !is_leaf_i;
          state_d    = is_leaf_i ? ST_LEAF : ST_PAIR;
        end
      end
      ST_LEAF: begin
        ctl_o.emit_leaf = 1'b1;
        if (slot_q == LAST_SLOT) begin
          slot_d  = '0;
          state_d = ST_WB;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      ST_PAIR: begin
        cmp_d.valid = 1'b1;
        cmp_d.last  = pair_last;
        cmp_d.slot  = slot_q;
        cmp_d.k     = k_q;
        cmp_d.j     = j;
        if (pair_last) begin
          k_d = '0;
          if (slot_q == '0) begin
            state_d = ST_GAP;
          end else if (slot_q == LAST_SLOT) begin
            state_d = ST_DRAIN;
          end else begin
            slot_d = slot_q + SLOT_W'(1);
          end
        end else begin
          k_d = k_q + SLOT_W'(1);
        end
      end
      ST_GAP: begin
        state_d = ST_FIN0;
      end
      ST_FIN0: begin
        ctl_o.fin0 = 1'b1;
        slot_d     = SLOT_W'(1);
        k_d        = '0;
        state_d    = ST_PAIR;
      end
      ST_DRAIN: begin
        slot_d  = '0;
        state_d = ST_WB;
      end
      ST_WB: begin
        mem_o.cost_we = 1'b1;
        mem_o.prim_we = slot_q == '0;
        if (slot_q == LAST_SLOT) begin
          slot_d  = '0;
          state_d = ST_IDLE;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      k_q     <= '0;
      first_q <= 1'b0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      k_q     <= k_d;
      first_q <= first_d;
      cmp_q   <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ni_q      <= node_id_i;
      ni_base_q <= node_base(node_id_i);
      lc_base_q <= node_base(left_child_i);
      rc_base_q <= rc_oob ? '0 : node_base(rc_full[NODE_W-1:0]);
      rc_oob_q  <= rc_oob;
      area_q    <= box_area_i;
    end
  end

endmodule

// ===== rtl/core/wbc_acc.sv =====
`timescale 1ns / 1ps

module wbc_acc import wbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  logic [COST_W-1:0] lcost_i,
  input  logic [COST_W-1:0] rcost_i,
  input  logic [PRIM_W-1:0] lprim_i,
  input  logic [PRIM_W-1:0] rprim_i,
  output logic [COST_W-1:0] wb_cost_o,
  output logic [PRIM_W-1:0] wb_prim_o,
  output logic              res_valid_o,
  output logic [SLOT_W-1:0] res_slot_o,
  output logic [COST_W-1:0] res_cost_o,
  output logic [1:0]        res_kind_o,
  output logic [SLOT_W-1:0] res_left_o,
  output logic [SLOT_W-1:0] res_right_o,
  output logic [PRIM_W-1:0] res_prims_o,
  output logic              res_last_o
);

  logic [COST_W-1:0] acc_cost_q, acc_cost_d;
  kind_e             acc_kind_q, acc_kind_d;
  logic [SLOT_W-1:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic [COST_W-1:0] cleaf_q;
  logic [PRIM_W-1:0] prims_q;
  logic [COST_W-1:0] slot_buf_q [SLOT_COUNT];

  logic              res_valid_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [COST_W-1:0] res_cost_q;
  kind_e             res_kind_q;
  logic [SLOT_W-1:0] res_l_q, res_r_q;

  logic [COST_W-1:0] rcost, cand, cint, cleaf_d;
  logic              better;
  logic [PRIM_W:0]   prim_sum;
  logic [PRIM_W-1:0] prim_sat;
  logic [PRIM_W+COST_W-1:0] prod;
  logic              emit_cmp, emit;
  logic [SLOT_W-1:0] out_slot;
  logic [COST_W-1:0] out_cost;
  kind_e             out_kind;
  logic [SLOT_W-1:0] out_l, out_r;

  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_INF : s[COST_W-1:0];
  endfunction

  assign rcost  = ctl_i.rc_oob ? COST_INF : rcost_i;
  assign cand   = sat_add(lcost_i, rcost);
  assign better = ctl_i.cmp.valid && (cand < acc_cost_q);
  assign cint   = sat_add(acc_cost_q, ctl_i.area);

  assign prim_sum = {1'b0, lprim_i} + (ctl_i.rc_oob ? '0 : {1'b0, rprim_i});
  assign prim_sat = prim_sum[PRIM_W] ? '1 : prim_sum[PRIM_W-1:0];
  assign prod     = (PRIM_W + COST_W)'(prim_sat) * (PRIM_W + COST_W)'(ctl_i.area);

  always_comb begin
    if (prim_sat > PRIM_W'(LEAF_LIMIT)) begin
      cleaf_d = COST_INF;
    end else if (prod > (PRIM_W + COST_W)'(COST_INF)) begin
      cleaf_d = COST_INF;
    end else begin
      cleaf_d = prod[COST_W-1:0];
    end
  end

  always_comb begin
    acc_cost_d = acc_cost_q;
    acc_kind_d = acc_kind_q;
    acc_l_d    = acc_l_q;
    acc_r_d    = acc_r_q;
    if (ctl_i.init) begin
      acc_cost_d = COST_INF;
      acc_kind_d = KIND_INTERNAL;
      acc_l_d    = NO_SLOT;
      acc_r_d    = NO_SLOT;
    end else if (ctl_i.fin0) begin
      if (cleaf_q < cint) begin
        acc_cost_d = cleaf_q;
        acc_kind_d = KIND_LEAF;
      end else begin
        acc_cost_d = cint;
        acc_kind_d = KIND_INTERNAL;
      end
    end else if (better) begin
      acc_cost_d = cand;
      acc_l_d    = ctl_i.cmp.k;
      acc_r_d    = ctl_i.cmp.j;
      if (ctl_i.cmp.slot != '0) begin
        acc_kind_d = KIND_DISTRIBUTE;
      end
    end
  end

  assign emit_cmp = ctl_i.cmp.valid && ctl_i.cmp.last && (ctl_i.cmp.slot != '0);
  assign emit     = emit_cmp || ctl_i.fin0 || ctl_i.emit_leaf;

  always_comb begin
    if (ctl_i.emit_leaf) begin
      out_slot = ctl_i.idx;
      out_cost = ctl_i.area;
      out_kind = KIND_LEAF;
      out_l    = NO_SLOT;
      out_r    = NO_SLOT;
    end else begin
      out_slot = ctl_i.fin0 ? '0 : ctl_i.cmp.slot;
      out_cost = acc_cost_d;
      out_kind = acc_kind_d;
      out_l    = acc_l_d;
      out_r    = acc_r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_cost_q <= acc_cost_d;
    acc_kind_q <= acc_kind_d;
    acc_l_q    <= acc_l_d;
    acc_r_q    <= acc_r_d;
    if (ctl_i.init && ctl_i.leaf) begin
      prims_q <= PRIM_W'(1);
    end else if (ctl_i.prim_valid) begin
      prims_q <= prim_sat;
      cleaf_q <= cleaf_d;
    end
    if (emit) begin
      res_slot_q           <= out_slot;
      res_cost_q           <= out_cost;
      res_kind_q           <= out_kind;
      res_l_q              <= out_l;
      res_r_q              <= out_r;
      slot_buf_q[out_slot] <= out_cost;
    end
  end

  assign wb_cost_o   = slot_buf_q[ctl_i.idx];
  assign wb_prim_o   = prims_q;
  assign res_valid_o = res_valid_q;
  assign res_slot_o  = res_slot_q;
  assign res_cost_o  = res_cost_q;
  assign res_kind_o  = res_kind_q;
  assign res_left_o  = res_l_q;
  assign res_right_o = res_r_q;
  assign res_prims_o = prims_q;
  assign res_last_o  = res_slot_q == LAST_SLOT;

endmodule

// ===== rtl/core/wbc_checker.sv =====
`timescale 1ns / 1ps

module wbc_checker import wbc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [SLOT_W-1:0] slot_o,
  input logic [1:0]        decision_kind_o,
  input logic              last_slot_o
);

  // results belong to a node transaction still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside a transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_slot_o) |-> (slot_o == LAST_SLOT))
    else $error("last flag on wrong slot");

  // slot 0 never distributes to children
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (slot_o == '0)) |-> (decision_kind_o != KIND_DISTRIBUTE))
    else $error("distribute decision on slot 0");

endmodule

bind wide_bvh_collapse_cost_dp_unit wbc_checker u_checker (.*);

// ===== tb/sv/tb_wide_bvh_collapse_cost_dp_unit.sv =====
`timescale 1ns / 1ps

module tb_wide_bvh_collapse_cost_dp_unit;
  import wbc_pkg::*;

  typedef struct packed {
    node_t             node;
    logic              leaf;
    node_t             lc;
    logic [COST_W-1:0] area;
    logic              typed;
    logic [COST_W-1:0] exp_cost;
    logic [PRIM_W-1:0] exp_prims;
  } stim_row_t;

  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] split_l;
    logic [SLOT_W-1:0] split_r;
  } slot_choice_t;

  typedef struct {
    node_t             node;
    logic [SLOT_W-1:0] slot;
    logic [COST_W-1:0] cost;
    kind_e             kind;
    logic [SLOT_W-1:0] split_l;
    logic [SLOT_W-1:0] split_r;
    logic [PRIM_W-1:0] prims;
    logic              last;
  } slot_result_t;

  localparam int DIR_N      = 22;
  localparam int RAND_ITEMS = 198;

  // leaf rows carry the expected cost and primitive count typed in
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{12'd0,    1'b1, 12'd0,    32'h0001_0000, 1'b1, 32'h0001_0000, 8'd1},
    '{12'd1,    1'b1, 12'd0,    32'h0002_0000, 1'b1, 32'h0002_0000, 8'd1},
    '{12'd2,    1'b0, 12'd0,    32'h0000_8000, 1'b0, 32'h0,         8'd0},
    '{12'd3,    1'b1, 12'd0,    32'h0000_0000, 1'b1, 32'h0000_0000, 8'd1},
    '{12'd4,    1'b0, 12'd2,    32'h0001_8000, 1'b0, 32'h0,         8'd0},
    '{12'd5,    1'b1, 12'd0,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'd1},
    '{12'd6,    1'b0, 12'd4,    32'h0000_4000, 1'b0, 32'h0,         8'd0},
    '{12'd7,    1'b1, 12'hFFF,  32'h0000_0001, 1'b1, 32'h0000_0001, 8'd1},
    '{12'd8,    1'b0, 12'd3,    32'h0010_0000, 1'b0, 32'h0,         8'd0},
    '{12'd9,    1'b1, 12'd0,    32'h0001_0000, 1'b1, 32'h0001_0000, 8'd1},
    '{12'd10,   1'b1, 12'd0,    32'h0001_0000, 1'b1, 32'h0001_0000, 8'd1},
    '{12'd11,   1'b0, 12'd9,    32'h0000_0000, 1'b0, 32'h0,         8'd0},
    '{12'd4095, 1'b1, 12'd0,    32'h8000_0000, 1'b1, 32'h8000_0000, 8'd1},
    '{12'd13,   1'b0, 12'd4095, 32'h0000_1000, 1'b0, 32'h0,         8'd0},
    '{12'd4094, 1'b1, 12'd0,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'd1},
    '{12'd14,   1'b0, 12'd4094, 32'h7FFF_FFFF, 1'b0, 32'h0,         8'd0},
    '{12'hAAA,  1'b1, 12'h555,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA, 8'd1},
    '{12'h555,  1'b1, 12'hAAA,  32'h5555_5555, 1'b1, 32'h5555_5555, 8'd1},
    '{12'd15,   1'b0, 12'd0,    32'hFFFF_FFFF, 1'b0, 32'h0,         8'd0},
    '{12'd16,   1'b0, 12'd10,   32'h0003_0000, 1'b0, 32'h0,         8'd0},
    '{12'd0,    1'b0, 12'd2,    32'h0000_0100, 1'b0, 32'h0,         8'd0},
    '{12'd17,   1'b0, 12'd15,   32'h0000_0010, 1'b0, 32'h0,         8'd0}
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  node_t             node_id_i      = '0;
  logic              is_leaf_i      = 1'b0;
  node_t             left_child_i   = '0;
  logic [COST_W-1:0] box_area_i     = '0;
  logic              result_valid_o;
  logic [SLOT_W-1:0] slot_o;
  logic [COST_W-1:0] slot_cost_o;
  logic [1:0]        decision_kind_o;
  logic [SLOT_W-1:0] split_left_o;
  logic [SLOT_W-1:0] split_right_o;
  logic [PRIM_W-1:0] primitive_total_o;
  logic              last_slot_o;

  logic [COST_W-1:0] node_costs     [TREE_NODES][SLOT_COUNT];
  logic [PRIM_W-1:0] node_prims     [TREE_NODES];
  bit                node_written   [TREE_NODES];

  slot_result_t pending_slots [$];
  int errors       = 0;
  int nodes_sent   = 0;
  int leaves_sent  = 0;
  int results_seen = 0;

  wide_bvh_collapse_cost_dp_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .node_id_i        (node_id_i),
    .is_leaf_i        (is_leaf_i),
    .left_child_i     (left_child_i),
    .box_area_i       (box_area_i),
    .result_valid_o   (result_valid_o),
    .slot_o           (slot_o),
    .slot_cost_o      (slot_cost_o),
    .decision_kind_o  (decision_kind_o),
    .split_left_o     (split_left_o),
    .split_right_o    (split_right_o),
    .primitive_total_o(primitive_total_o),
    .last_slot_o      (last_slot_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [COST_W-1:0] cost_sum(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_INF : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] child_cost(input int idx, input int s);
    if (idx >= TREE_NODES) return COST_INF;
    return node_costs[idx][s];
  endfunction

  function automatic logic [PRIM_W-1:0] child_prims(input int idx);
    if (idx >= TREE_NODES) return '0;
    return node_prims[idx];
  endfunction

  // one dynamic-programming step: slot costs, choices and primitive count
  task automatic compute_slot_vector(input stim_row_t row, input bit keep);
    logic [COST_W-1:0] cost [SLOT_COUNT];
    slot_choice_t      dec  [SLOT_COUNT];
    logic [PRIM_W:0]   psum;
    logic [PRIM_W-1:0] prims;
    logic [COST_W-1:0] best, cleaf, cint, b, c;
    logic [SLOT_W-1:0] bl, br, sl, sr;
    logic [63:0]       prod;
    bit                found;
    int                lc, rc;
    slot_result_t      res;
    lc = int'(row.lc);
    rc = lc + 1;
    if (row.leaf) begin
      prims = 8'd1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cost[i] = row.area;
        dec[i]  = '{KIND_LEAF, NO_SLOT, NO_SLOT};
      end
    end else begin
      psum  = {1'b0, child_prims(lc)} + {1'b0, child_prims(rc)};
      prims = psum[PRIM_W] ? 8'hFF : psum[PRIM_W-1:0];
      if (prims <= LEAF_LIMIT) begin
        prod  = 64'(prims) * 64'(row.area);
        cleaf = (prod > 64'(COST_INF)) ? COST_INF : prod[COST_W-1:0];
      end else begin
        cleaf = COST_INF;
      end
      best = COST_INF;
      bl   = NO_SLOT;
      br   = NO_SLOT;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        c = cost_sum(child_cost(lc, k), child_cost(rc, SLOT_COUNT - 1 - k));
        if (c < best) begin
          best = c;
          bl   = SLOT_W'(k);
          br   = SLOT_W'(SLOT_COUNT - 1 - k);
        end
      end
      cint = cost_sum(best, row.area);
      if (cleaf < cint) begin
        cost[0] = cleaf;
        dec[0]  = '{KIND_LEAF, bl, br};
      end else begin
        cost[0] = cint;
        dec[0]  = '{KIND_INTERNAL, bl, br};
      end
      for (int i = 1; i < SLOT_COUNT; i++) begin
        b     = cost[i-1];
        found = 1'b0;
        sl    = '0;
        sr    = '0;
        for (int k = 0; k < i; k++) begin
          c = cost_sum(child_cost(lc, k), child_cost(rc, i - k - 1));
          if (c < b) begin
            b     = c;
            found = 1'b1;
            sl    = SLOT_W'(k);
            sr    = SLOT_W'(i - k - 1);
          end
        end
        cost[i] = b;
        if (found) dec[i] = '{KIND_DISTRIBUTE, sl, sr};
        else dec[i] = dec[i-1];
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      node_costs[row.node][i] = cost[i];
      if (keep) begin
        res = '{row.node, SLOT_W'(i), cost[i], dec[i].kind, dec[i].split_l,
                dec[i].split_r, prims, (i == SLOT_COUNT - 1)};
        pending_slots.push_back(res);
      end
    end
    node_prims[row.node] = prims;
  endtask

  task automatic send_node(input stim_row_t row);
    slot_result_t res;
    node_id_i      <= row.node;
    is_leaf_i      <= row.leaf;
    left_child_i   <= row.lc;
    box_area_i     <= row.area;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    compute_slot_vector(row, !row.typed);
    if (row.typed) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        res = '{row.node, SLOT_W'(i), row.exp_cost, KIND_LEAF, NO_SLOT, NO_SLOT,
                row.exp_prims, (i == SLOT_COUNT - 1)};
        pending_slots.push_back(res);
      end
    end
    node_written[row.node] = 1'b1;
    nodes_sent++;
    if (row.leaf) leaves_sent++;
  endtask

  task automatic idle_gap(input int n);
    int r, len;
    r = $urandom_range(0, 99);
    if ((n / 25) % 3 == 1) len = 0;
    else if (r < 50) len = 0;
    else if (r < 85) len = $urandom_range(1, 3);
    else if (r < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk_i);
  endtask

  function automatic node_t pick_pool_node();
    if ($urandom_range(0, 4) == 0) return node_t'(4048 + $urandom_range(0, 47));
    return node_t'($urandom_range(0, 47));
  endfunction

  function automatic logic [COST_W-1:0] random_area();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COST_INF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input slot_result_t want,
                             input logic [COST_W-1:0] exp_v,
                             input logic [COST_W-1:0] got_v);
    if (got_v !== exp_v)
      report_mismatch($sformatf("node %0d slot %0d %s: exp %h got %h",
                                want.node, want.slot, name, exp_v, got_v));
  endtask

  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction, slot %0d cost %h",
                                  slot_o, slot_cost_o));
      end else begin
        want = pending_slots.pop_front();
        check_field("slot", want, 32'(want.slot), 32'(slot_o));
        check_field("cost", want, want.cost, slot_cost_o);
        check_field("kind", want, 32'(want.kind), 32'(decision_kind_o));
        check_field("split_left", want, 32'(want.split_l), 32'(split_left_o));
        check_field("split_right", want, 32'(want.split_r), 32'(split_right_o));
        check_field("prims", want, 32'(want.prims), 32'(primitive_total_o));
        check_field("last", want, 32'(want.last), 32'(last_slot_o));
      end
    end
  end

  initial begin
    stim_row_t row;
    node_t     bases [$];
    int        idx;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      send_node(DIR_ROWS[r]);
      idle_gap(r);
    end
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      bases.delete();
      for (int j = 0; j < 96; j++) begin
        idx = (j < 48) ? j : 4000 + j;
        if (node_written[idx] && (idx == TREE_NODES - 1 || node_written[idx+1]))
          bases.push_back(node_t'(idx));
      end
      row      = '0;
      row.node = pick_pool_node();
      row.area = random_area();
      row.leaf = (bases.size() == 0) || ($urandom_range(0, 9) < 3);
      row.lc   = row.leaf ? node_t'($urandom) : bases[$urandom_range(0, bases.size() - 1)];
      send_node(row);
      if (n == 90 || n == 170) wait_drained();
      else idle_gap(n);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d node transactions (%0d leaves, %0d inner), %0d slot results seen",
             nodes_sent, leaves_sent, nodes_sent - leaves_sent, results_seen);
    if (errors == 0 && pending_slots.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_slots.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
